// ===== rtl/wavelength_to_cie_xyz_macros.svh =====
// assertion macros used by the wavelength to cie xyz control block
`ifndef WAVELENGTH_TO_CIE_XYZ_MACROS_SVH
`define WAVELENGTH_TO_CIE_XYZ_MACROS_SVH
`ifndef ASSERT_OFF
// check that holds outside reset
`define WCX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("wcx assertion failed");
// check that also covers the reset cycles
`define WCX_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("wcx reset assertion failed");
`else
`define WCX_ASSERT(lbl, prop)
`define WCX_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/wcx_pkg.sv =====
// shared types, stage map and lobe constants of the cie xyz block
package wcx_pkg;

    localparam int W_W      = 16;
    localparam int OUT_W    = 16;
    localparam int LOBE_CNT = 7;

    // exp(-u) table
    localparam int EXP_TABLE_DEPTH_DEF = 256;
    localparam int EXP_U_MAX           = 16;
    localparam int EXP_U_SH            = $clog2(EXP_U_MAX);
    localparam int TAYLOR_TERMS        = 24;
    localparam int ROM_W               = 17;
    localparam int F_W                 = 16;

    // u = (s*s)>>1 in q.44, far tail at u >= EXP_U_MAX
    localparam int U_FRAC = 44;
    localparam int U_W    = U_FRAC + EXP_U_SH;
    localparam int S_W    = U_W / 2 + 1;

    // weighted lobe and channel sums
    localparam int WP_W      = 35;
    localparam int SUM_W     = WP_W + 2;
    localparam int DROP_BITS = 18;
    localparam int OUT_MAX   = 32767;
    localparam int OUT_MIN   = -32768;

    // pipeline stage map
    localparam int ST_IN     = 0;
    localparam int ST_SEL    = 1;
    localparam int ST_MUL    = 2;
    localparam int ST_SQR    = 3;
    localparam int ST_IDX    = 4;
    localparam int ST_ROM    = 5;
    localparam int ST_INT    = 6;
    localparam int ST_EXP    = 7;
    localparam int ST_WGT    = 8;
    localparam int ST_SUM    = 9;
    localparam int ST_OUT    = 10;
    localparam int STAGE_CNT = 11;

    typedef logic [STAGE_CNT-1:0] pipe_en_t;
    typedef logic signed [WP_W-1:0] wp_t;

    typedef enum logic [1:0] {
        CH_X,
        CH_Y,
        CH_Z
    } chan_t;

    localparam int CH_CNT = 3;

    // centres q10.6, widths q0.16, weights signed q.16
    localparam logic [W_W-1:0] LOBE_CENTRE [LOBE_CNT] = '{
        16'd38387, 16'd28288, 16'd32070, 16'd36403, 16'd33978, 16'd27968, 16'd29376
    };
    localparam logic [15:0] LOBE_LEFT [LOBE_CNT] = '{
        16'd1730, 16'd4089, 16'd3211, 16'd1396, 16'd4017, 16'd5538, 16'd2523
    };
    localparam logic [15:0] LOBE_RIGHT [LOBE_CNT] = '{
        16'd2117, 16'd2451, 16'd2503, 16'd1619, 16'd2110, 16'd1822, 16'd4751
    };
    localparam logic signed [17:0] LOBE_WEIGHT [LOBE_CNT] = '{
        18'sd69206, 18'sd23724, -18'sd4260, 18'sd53805, 18'sd18743, 18'sd79757, 18'sd44630
    };
    localparam chan_t LOBE_CHAN [LOBE_CNT] = '{
        CH_X, CH_X, CH_X, CH_Y, CH_Y, CH_Z, CH_Z
    };

endpackage

// ===== rtl/wcx_ctrl.sv =====
// valid bits and stall control of the cie xyz pipeline
`include "wavelength_to_cie_xyz_macros.svh"

module wcx_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output wcx_pkg::pipe_en_t en
);
    import wcx_pkg::*;

    localparam pipe_en_t FULL_MASK = '1;

    pipe_en_t valid_reg;
    pipe_en_t valid_next;
    pipe_en_t up_valid;
    pipe_en_t stage_rdy;
    logic     in_acc;
    logic     out_acc;
    int       occ;
    int       occ_delta;

    // a stage may load when it or some later stage has a hole or the sink takes
    always_comb begin
        up_valid = {valid_reg[STAGE_CNT-2:0], s_valid};
        for (int k = 0; k < STAGE_CNT; k++) begin
            stage_rdy[k] = m_ready || ((valid_reg >> k) != (FULL_MASK >> k));
        end
        en         = stage_rdy & up_valid;
        valid_next = (stage_rdy & up_valid) | (~stage_rdy & valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign s_ready = stage_rdy[ST_IN];
    assign m_valid = valid_reg[ST_OUT];
    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    // items in flight and their change from the handshakes of the current cycle
    assign occ       = $countones(valid_reg);
    assign occ_delta = int'(in_acc) - int'(out_acc);

    `WCX_ASSERT_RST(a_reset_clears, !aresetn |=> (valid_reg == '0))
    `WCX_ASSERT(a_full_when_blocked, !s_ready |-> ((&valid_reg) && !m_ready))
    `WCX_ASSERT(a_item_count, $past(aresetn) |-> (occ == $past(occ) + $past(occ_delta)))

endmodule

// ===== rtl/wcx_lobe.sv =====
// one gaussian lobe lane: distance, square, exp table lookup, weight
module wcx_lobe #(
    parameter int LOBE_IDX        = 0,
    parameter int EXP_TABLE_DEPTH = wcx_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  wcx_pkg::pipe_en_t       en,
    input  logic [wcx_pkg::W_W-1:0] w,
    output wcx_pkg::wp_t            wp
);
    import wcx_pkg::*;

    localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PROD_W = U_W + IDX_W;
    localparam int IDX_LO = U_FRAC + EXP_U_SH;
    localparam int F_LO   = IDX_LO - F_W;
    localparam logic [63:0] EXP_STEP = (64'(EXP_U_MAX) << 31) / EXP_TABLE_DEPTH;

    typedef logic [ROM_W-1:0] rom_t [EXP_TABLE_DEPTH+1];

    // exp(-k*umax/depth) in q.16, by repeated multiply of exp(-step)
    function automatic rom_t build_rom(input logic [63:0] step);
        rom_t               rom;
        logic [63:0]        term;
        logic [63:0]        e;
        logic [63:0]        r;
        logic signed [63:0] acc;
        int                 n;
        int                 k;
        term = 64'd1 << 31;
        acc  = $signed(term);
        for (n = 1; n <= TAYLOR_TERMS; n++) begin
            term = ((term * step) >> 31) / 64'(n);
            if (n % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        r = (acc > 0) ? $unsigned(acc) : 64'd0;
        e = 64'd1 << 31;
        rom[0] = ROM_W'((e + 64'd16384) >> 15);
        for (k = 1; k <= EXP_TABLE_DEPTH; k++) begin
            e      = (e * r + (64'd1 << 30)) >> 31;
            rom[k] = ROM_W'((e + 64'd16384) >> 15);
        end
        return rom;
    endfunction

    localparam rom_t EXP_ROM = build_rom(EXP_STEP);

    logic [W_W:0]         diff;
    logic                 below;
    logic [15:0]          ad_reg;
    logic [15:0]          t_reg;
    logic [31:0]          s_full;
    logic [S_W-1:0]       s_reg;
    logic                 tail1_reg;
    logic [2*S_W-1:0]     sq_full;
    logic [U_W-1:0]       u_reg;
    logic                 tail2_reg;
    logic [PROD_W-1:0]    p_full;
    logic [IDX_W-1:0]     idx_reg;
    logic [F_W-1:0]       f4_reg;
    logic                 tail3_reg;
    logic [ROM_W-1:0]     hi_reg;
    logic [ROM_W-1:0]     lo_reg;
    logic [F_W-1:0]       f5_reg;
    logic                 tail4_reg;
    logic [ROM_W-1:0]     lo_clip;
    logic [ROM_W-1:0]     span;
    logic [ROM_W+F_W-1:0] pf_reg;
    logic [ROM_W-1:0]     hi6_reg;
    logic                 tail5_reg;
    logic [ROM_W-1:0]     g_next;
    logic [ROM_W-1:0]     g_reg;
    wp_t                  wp_next;
    wp_t                  wp_reg;

    // distance from the centre, width picked by side
    assign diff  = {1'b0, w} - {1'b0, LOBE_CENTRE[LOBE_IDX]};
    assign below = diff[W_W];

    always_ff @(posedge aclk) begin
        if (en[ST_SEL]) begin
            ad_reg <= below ? W_W'((W_W+1)'(0) - diff) : diff[W_W-1:0];
            t_reg  <= below ? LOBE_LEFT[LOBE_IDX] : LOBE_RIGHT[LOBE_IDX];
        end
    end

    // s = |d| * t, early tail when s is already too large to square
    assign s_full = ad_reg * t_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_MUL]) begin
            s_reg     <= s_full[S_W-1:0];
            tail1_reg <= |s_full[31:S_W];
        end
    end

    // u = s*s/2, tail when u reaches the table range
    assign sq_full = s_reg * s_reg;

    always_ff @(posedge aclk) begin
        if (en[ST_SQR]) begin
            u_reg     <= sq_full[U_W:1];
            tail2_reg <= tail1_reg | sq_full[U_W+1];
        end
    end

    // table position: u * depth / umax
    assign p_full = PROD_W'(u_reg) * PROD_W'(EXP_TABLE_DEPTH);

    always_ff @(posedge aclk) begin
        if (en[ST_IDX]) begin
            idx_reg   <= p_full[IDX_LO +: IDX_W];
            f4_reg    <= p_full[F_LO +: F_W];
            tail3_reg <= tail2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_ROM]) begin
            hi_reg    <= EXP_ROM[idx_reg];
            lo_reg    <= EXP_ROM[idx_reg + IDX_W'(1)];
            f5_reg    <= f4_reg;
            tail4_reg <= tail3_reg;
        end
    end

    // linear interpolation between neighbours
    assign lo_clip = (lo_reg > hi_reg) ? hi_reg : lo_reg;
    assign span    = hi_reg - lo_clip;

    always_ff @(posedge aclk) begin
        if (en[ST_INT]) begin
            pf_reg    <= span * f5_reg;
            hi6_reg   <= hi_reg;
            tail5_reg <= tail4_reg;
        end
    end

    assign g_next = hi6_reg
                  - ROM_W'(((ROM_W+F_W+1)'(pf_reg) + (ROM_W+F_W+1)'(32768)) >> F_W);

    always_ff @(posedge aclk) begin
        if (en[ST_EXP]) begin
            g_reg <= tail5_reg ? '0 : g_next;
        end
    end

    assign wp_next = WP_W'(LOBE_WEIGHT[LOBE_IDX]) * WP_W'($signed({1'b0, g_reg}));

    always_ff @(posedge aclk) begin
        if (en[ST_WGT]) begin
            wp_reg <= wp_next;
        end
    end

    assign wp = wp_reg;

endmodule

// ===== rtl/wcx_mix.sv =====
// channel sums of the weighted lobes, rounding and saturation to q2.14
module wcx_mix (
    input  logic                             aclk,
    input  wcx_pkg::pipe_en_t                en,
    input  wcx_pkg::wp_t                     wp [wcx_pkg::LOBE_CNT],
    output logic signed [wcx_pkg::OUT_W-1:0] m_x_value,
    output logic signed [wcx_pkg::OUT_W-1:0] m_y_value,
    output logic signed [wcx_pkg::OUT_W-1:0] m_z_value
);
    import wcx_pkg::*;

    // round half up to q.14, then clip
    function automatic logic signed [OUT_W-1:0] to_q14(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0] b;
        b = (SUM_W+1)'(s) + (SUM_W+1)'(1 << (DROP_BITS - 1));
        b = b >>> DROP_BITS;
        if (b > OUT_MAX) begin
            return OUT_W'(OUT_MAX);
        end else if (b < OUT_MIN) begin
            return OUT_W'(OUT_MIN);
        end
        return OUT_W'(b);
    endfunction

    logic signed [SUM_W-1:0] sum_next [CH_CNT];
    logic signed [SUM_W-1:0] sum_reg  [CH_CNT];
    logic signed [OUT_W-1:0] x_reg;
    logic signed [OUT_W-1:0] y_reg;
    logic signed [OUT_W-1:0] z_reg;

    always_comb begin
        for (int c = 0; c < CH_CNT; c++) begin
            sum_next[c] = '0;
        end
        for (int i = 0; i < LOBE_CNT; i++) begin
            sum_next[LOBE_CHAN[i]] = sum_next[LOBE_CHAN[i]] + SUM_W'(wp[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_SUM]) begin
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[ST_OUT]) begin
            x_reg <= to_q14(sum_reg[CH_X]);
            y_reg <= to_q14(sum_reg[CH_Y]);
            z_reg <= to_q14(sum_reg[CH_Z]);
        end
    end

    assign m_x_value = x_reg;
    assign m_y_value = y_reg;
    assign m_z_value = z_reg;

endmodule

// ===== rtl/wavelength_to_cie_xyz.sv =====
// top level: wavelength in, cie 1931 x, y, z matching values out
//
// input channel: s_valid / s_ready with s_wavelength_q, nanometres in
// unsigned q10.6. result channel: m_valid / m_ready with m_x_value,
// m_y_value and m_z_value, signed q2.14, saturated to the 16-bit range.
// each value is a sum of weighted piecewise gaussian lobes (three for x,
// one of them negative, two each for y and z), exp(-u) read from a table
// with linear interpolation between neighbouring entries.
// pipeline: 11 register stages. throughput: one item per cycle unless the
// receiver stalls a full pipe, set by the seven parallel lobe lanes, each a
// chain of registered multiplies and a two-read exp table lookup.
// reset (aresetn low at a clock edge) clears every valid bit; data
// registers keep whatever they hold and are never shown unqualified.
// when the receiver stalls, items move on into empty stages behind the
// output register, so s_ready stays high until every stage holds an item;
// nothing is dropped or repeated. the block keeps no state between items.
module wavelength_to_cie_xyz #(
    parameter int EXP_TABLE_DEPTH = wcx_pkg::EXP_TABLE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [wcx_pkg::W_W-1:0]          s_wavelength_q,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [wcx_pkg::OUT_W-1:0] m_x_value,
    output logic signed [wcx_pkg::OUT_W-1:0] m_y_value,
    output logic signed [wcx_pkg::OUT_W-1:0] m_z_value
);
    import wcx_pkg::*;

    pipe_en_t       en;
    logic [W_W-1:0] w_reg;
    wp_t            wp [LOBE_CNT];

    // stage loads and valid bits for the whole pipe
    wcx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .en      (en)
    );

    // input register, shared by all lanes
    always_ff @(posedge aclk) begin
        if (en[ST_IN]) begin
            w_reg <= s_wavelength_q;
        end
    end

    // one lane per lobe, all in lockstep
    for (genvar i = 0; i < LOBE_CNT; i++) begin : g_lobe
        wcx_lobe #(
            .LOBE_IDX        (i),
            .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
        ) u_lobe (
            .aclk (aclk),
            .en   (en),
            .w    (w_reg),
            .wp   (wp[i])
        );
    end

    // channel sums and the output register
    wcx_mix u_mix (
        .aclk      (aclk),
        .en        (en),
        .wp        (wp),
        .m_x_value (m_x_value),
        .m_y_value (m_y_value),
        .m_z_value (m_z_value)
    );

endmodule
